// ===== sv/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared constants and types of the line follower PD drive block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int unsigned LINE_BITS_W  = 8;
   localparam int unsigned SPEED_W      = 8;
   localparam int unsigned DIST_W       = 10;
   localparam int unsigned GAIN_W       = 8;
   localparam int unsigned DUTY_W       = 8;
   localparam int unsigned ERR_W        = 8;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 10;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 8'd1;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = 8'd0;
   localparam logic [DIST_W-1:0] OBSTACLE_LIMIT_RST = 10'd30;

   localparam logic signed [ERR_W-1:0] ERR_CENTER = 8'sd0;
   localparam logic signed [ERR_W-1:0] ERR_INNER  = 8'sd12;
   localparam logic signed [ERR_W-1:0] ERR_EDGE   = 8'sd70;
   localparam logic signed [ERR_W-1:0] ERR_LOST   = 8'sd60;
   localparam logic signed [ERR_W-1:0] ERR_OUTER  = 8'sd40;
   localparam logic signed [ERR_W-1:0] ERR_MID    = 8'sd20;

   localparam logic signed [9:0] DRIVE_MAX = 10'sd240;
   localparam logic signed [9:0] SIDE_BIAS = 10'sd25;
   localparam logic [9:0]        DUTY_MAX  = 10'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN      = 2'd0,
      CSR_DERIV_GAIN     = 2'd1,
      CSR_OBSTACLE_LIMIT = 2'd2
   } csr_index_type;

endpackage

// ===== sv/line_follower_pd_drive.sv =====
// ----------------------------------------------------------------------------
// line_follower_pd_drive
// PD line follower: sensor bits to signed error, PD term, saturated and
// biased left/right drive as direction plus duty, obstacle stop.
// ----------------------------------------------------------------------------
//  channel  handshake               word
//  req      req_valid / req_ready   line_bits, drive_speed, obstacle_distance
//  rsp      rsp_valid / rsp_ready   left/right reverse and duty, line_error
//  csr      csr_valid / csr_ready   csr_index, csr_data (ready always high)
//
//  An accepted request passes through the input register and then the result
//  register; one word per cycle sustained unless the result is stalled.
//  An input register feeds the error map, a 9x8 and a 9x9 multiplier and the
//  saturation logic, which load the result register.
//  Synchronous active-high reset clears valids and the error state and
//  restores the gains and the obstacle limit.
//  A stalled result holds its word; the input register still takes one more.
// ----------------------------------------------------------------------------
module line_follower_pd_drive (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lfpd_pkg::LINE_BITS_W-1:0]  req_line_bits,
   input  logic [lfpd_pkg::SPEED_W-1:0]      req_drive_speed,
   input  logic [lfpd_pkg::DIST_W-1:0]       req_obstacle_distance,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_left_reverse,
   output logic [lfpd_pkg::DUTY_W-1:0]       rsp_left_duty,
   output logic                              rsp_right_reverse,
   output logic [lfpd_pkg::DUTY_W-1:0]       rsp_right_duty,
   output logic signed [lfpd_pkg::ERR_W-1:0] rsp_line_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lfpd_pkg::*;

   logic [GAIN_W-1:0]      prop_gain_ff;
   logic [GAIN_W-1:0]      deriv_gain_ff;
   logic [DIST_W-1:0]      obstacle_limit_ff;

   logic                   s1_valid_ff;
   logic [LINE_BITS_W-1:0] s1_bits_ff;
   logic [SPEED_W-1:0]     s1_speed_ff;
   logic [DIST_W-1:0]      s1_dist_ff;

   logic signed [ERR_W-1:0] prev_error_ff;
   logic                    line_seen_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_left_reverse_ff;
   logic [DUTY_W-1:0]       rsp_left_duty_ff;
   logic                    rsp_right_reverse_ff;
   logic [DUTY_W-1:0]       rsp_right_duty_ff;
   logic signed [ERR_W-1:0] rsp_line_error_ff;

   logic                    advance;
   logic                    found;
   logic signed [ERR_W-1:0] err_in;
   logic signed [8:0]       diff;
   logic signed [8:0]       prop_s;
   logic signed [8:0]       deriv_s;
   logic signed [16:0]      p_term;
   logic signed [16:0]      d_term;
   logic signed [17:0]      pd;
   logic signed [17:0]      left_raw;
   logic signed [17:0]      right_raw;
   logic signed [9:0]       left_sat;
   logic signed [9:0]       right_sat;
   logic signed [9:0]       left_drv;
   logic signed [9:0]       right_drv;
   logic [9:0]              left_mag;
   logic [9:0]              right_mag;
   logic                    stop;
   logic                    near_center;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= PROP_GAIN_RST;
         deriv_gain_ff     <= DERIV_GAIN_RST;
         obstacle_limit_ff <= OBSTACLE_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PROP_GAIN:      prop_gain_ff      <= csr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:     deriv_gain_ff     <= csr_data[GAIN_W-1:0];
            CSR_OBSTACLE_LIMIT: obstacle_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_bits_ff  <= req_line_bits;
         s1_speed_ff <= req_drive_speed;
         s1_dist_ff  <= req_obstacle_distance;
      end
   end

   // error map in priority order
   always_comb begin
      found  = 1'b1;
      err_in = prev_error_ff;
      priority if (s1_bits_ff[3] && s1_bits_ff[4]) begin
         err_in = ERR_CENTER;
      end else if (s1_bits_ff[3]) begin
         err_in = -ERR_INNER;
      end else if (s1_bits_ff[4]) begin
         err_in = ERR_INNER;
      end else if (s1_bits_ff[0]) begin
         err_in = line_seen_ff ? -ERR_EDGE : ERR_LOST;
      end else if (s1_bits_ff[7]) begin
         err_in = line_seen_ff ? ERR_EDGE : -ERR_LOST;
      end else if (s1_bits_ff[1]) begin
         err_in = -ERR_OUTER;
      end else if (s1_bits_ff[6]) begin
         err_in = ERR_OUTER;
      end else if (s1_bits_ff[2]) begin
         err_in = -ERR_MID;
      end else if (s1_bits_ff[5]) begin
         err_in = ERR_MID;
      end else begin
         found = 1'b0;
      end
   end

   always_comb begin
      diff     = 9'(err_in) - 9'(prev_error_ff);
      prop_s   = $signed({1'b0, prop_gain_ff});
      deriv_s  = $signed({1'b0, deriv_gain_ff});
      p_term   = 17'(prop_s * err_in);
      d_term   = 17'(deriv_s * diff);
      pd       = 18'(p_term) + 18'(d_term);
      left_raw  = 18'($signed({1'b0, s1_speed_ff})) + pd;
      right_raw = 18'($signed({1'b0, s1_speed_ff})) - pd;

      if (left_raw > 18'(DRIVE_MAX)) begin
         left_sat = DRIVE_MAX;
      end else if (left_raw < -18'(DRIVE_MAX)) begin
         left_sat = -DRIVE_MAX;
      end else begin
         left_sat = left_raw[9:0];
      end
      if (right_raw > 18'(DRIVE_MAX)) begin
         right_sat = DRIVE_MAX;
      end else if (right_raw < -18'(DRIVE_MAX)) begin
         right_sat = -DRIVE_MAX;
      end else begin
         right_sat = right_raw[9:0];
      end

      near_center = (err_in > -ERR_OUTER) && (err_in < ERR_OUTER);
      left_drv  = near_center ? left_sat  : left_sat - SIDE_BIAS;
      right_drv = near_center ? right_sat + SIDE_BIAS : right_sat;

      left_mag  = left_drv[9]  ? 10'(-left_drv)  : 10'(left_drv);
      right_mag = right_drv[9] ? 10'(-right_drv) : 10'(right_drv);
      stop      = s1_dist_ff < obstacle_limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         line_seen_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            line_seen_ff <= found;
            if (found) begin
               prev_error_ff <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_line_error_ff    <= err_in;
         rsp_left_reverse_ff  <= !stop && left_drv[9];
         rsp_right_reverse_ff <= !stop && right_drv[9];
         rsp_left_duty_ff     <= stop ? '0 :
                                 (left_mag > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] :
                                 left_mag[DUTY_W-1:0];
         rsp_right_duty_ff    <= stop ? '0 :
                                 (right_mag > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] :
                                 right_mag[DUTY_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_reverse  = rsp_left_reverse_ff;
   assign rsp_left_duty     = rsp_left_duty_ff;
   assign rsp_right_reverse = rsp_right_reverse_ff;
   assign rsp_right_duty    = rsp_right_duty_ff;
   assign rsp_line_error    = rsp_line_error_ff;

endmodule

// ===== sv/lfpd_checker.sv =====
// ----------------------------------------------------------------------------
// lfpd_checker
// Port-level checks of the line follower PD drive, bound to the top level.
// ----------------------------------------------------------------------------
module lfpd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_left_reverse,
   input logic [lfpd_pkg::DUTY_W-1:0]       rsp_left_duty,
   input logic                              rsp_right_reverse,
   input logic [lfpd_pkg::DUTY_W-1:0]       rsp_right_duty,
   input logic signed [lfpd_pkg::ERR_W-1:0] rsp_line_error
);
   import lfpd_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_duty)
         && $stable(rsp_right_duty) && $stable(rsp_line_error))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_error >= -ERR_EDGE) && (rsp_line_error <= ERR_EDGE))
      else $error("line error out of range");

   a_reverse_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_left_reverse || rsp_left_duty != '0)
         && (!rsp_right_reverse || rsp_right_duty != '0))
      else $error("reverse with zero duty");

endmodule

bind line_follower_pd_drive lfpd_checker u_lfpd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_left_reverse  (rsp_left_reverse),
   .rsp_left_duty     (rsp_left_duty),
   .rsp_right_reverse (rsp_right_reverse),
   .rsp_right_duty    (rsp_right_duty),
   .rsp_line_error    (rsp_line_error)
);

// ===== tb/line_follower_pd_drive_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_pd_drive_test
// Self-checking bench for the PD line follower drive block. A scoreboard
// class keeps its own copy of the gains, stop distance, last error and
// line-found flag, predicts every drive word from each accepted sample and
// checks the results in order. Directed samples cover each lone sensor bit,
// the lost-line cases and the extremes; random phases with fresh gains follow.
// ----------------------------------------------------------------------------
module line_follower_pd_drive_test;
   import lfpd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 10;
   localparam int PHASE_WORDS = 175;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                    left_reverse;
      logic [DUTY_W-1:0]       left_duty;
      logic                    right_reverse;
      logic [DUTY_W-1:0]       right_duty;
      logic signed [ERR_W-1:0] line_error;
   } drive_word_type;

   class drive_scoreboard;
      drive_word_type          drive_expected[$];
      logic [GAIN_W-1:0]       prop_gain;
      logic [GAIN_W-1:0]       deriv_gain;
      logic [DIST_W-1:0]       obstacle_limit;
      logic signed [ERR_W-1:0] last_error;
      bit                      line_seen;
      int                      mismatches;

      function new();
         prop_gain = PROP_GAIN_RST;
         deriv_gain = DERIV_GAIN_RST;
         obstacle_limit = OBSTACLE_LIMIT_RST;
         last_error = '0;
         line_seen = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return drive_expected.size();
      endfunction

      task report(string msg);
         if (mismatches < 40) $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_PROP_GAIN: prop_gain = data[GAIN_W-1:0];
            CSR_DERIV_GAIN: deriv_gain = data[GAIN_W-1:0];
            CSR_OBSTACLE_LIMIT: obstacle_limit = data[DIST_W-1:0];
            default: ;
         endcase
      endfunction

      function int clamp_drive(int v);
         if (v > int'(DRIVE_MAX)) return int'(DRIVE_MAX);
         if (v < -int'(DRIVE_MAX)) return -int'(DRIVE_MAX);
         return v;
      endfunction

      function void drive_out(int v, bit stop, output logic rev, output logic [DUTY_W-1:0] duty);
         int mag;
         mag = (v < 0) ? -v : v;
         if (stop) begin
            rev = 0;
            duty = '0;
         end else begin
            rev = (v < 0);
            duty = (mag > int'(DUTY_MAX)) ? DUTY_MAX[DUTY_W-1:0] : mag[DUTY_W-1:0];
         end
      endfunction

      function string describe(drive_word_type w);
         return $sformatf("L(rev %0b duty %0d) R(rev %0b duty %0d) err %0d",
                          w.left_reverse, w.left_duty, w.right_reverse, w.right_duty,
                          w.line_error);
      endfunction

      function void note_request(logic [LINE_BITS_W-1:0] bits, logic [SPEED_W-1:0] speed,
                                 logic [DIST_W-1:0] distance);
         int             err;
         int             diff;
         int             pd;
         int             left;
         int             right;
         bit             found;
         bit             stop;
         drive_word_type w;
         found = 1;
         if (bits[3] && bits[4]) err = int'(ERR_CENTER);
         else if (bits[3]) err = -int'(ERR_INNER);
         else if (bits[4]) err = int'(ERR_INNER);
         else if (bits[0]) err = line_seen ? -int'(ERR_EDGE) : int'(ERR_LOST);
         else if (bits[7]) err = line_seen ? int'(ERR_EDGE) : -int'(ERR_LOST);
         else if (bits[1]) err = -int'(ERR_OUTER);
         else if (bits[6]) err = int'(ERR_OUTER);
         else if (bits[2]) err = -int'(ERR_MID);
         else if (bits[5]) err = int'(ERR_MID);
         else begin
            err = int'(last_error);
            found = 0;
         end
         diff = err - int'(last_error);
         if (found) last_error = err[ERR_W-1:0];
         line_seen = found;
         pd = int'(prop_gain) * err + int'(deriv_gain) * diff;
         left = clamp_drive(int'(speed) + pd);
         right = clamp_drive(int'(speed) - pd);
         if (err > -int'(ERR_OUTER) && err < int'(ERR_OUTER)) right += int'(SIDE_BIAS);
         else left -= int'(SIDE_BIAS);
         stop = (distance < obstacle_limit);
         drive_out(left, stop, w.left_reverse, w.left_duty);
         drive_out(right, stop, w.right_reverse, w.right_duty);
         w.line_error = err[ERR_W-1:0];
         drive_expected.push_back(w);
      endfunction

      task check_response(drive_word_type got);
         drive_word_type want;
         if (drive_expected.size() == 0) begin
            report($sformatf("unexpected word %s", describe(got)));
            return;
         end
         want = drive_expected.pop_front();
         if (got.left_reverse !== want.left_reverse || got.left_duty !== want.left_duty ||
             got.right_reverse !== want.right_reverse || got.right_duty !== want.right_duty ||
             got.line_error !== want.line_error)
            report($sformatf("got %s, want %s", describe(got), describe(want)));
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [LINE_BITS_W-1:0]     req_line_bits;
   logic [SPEED_W-1:0]         req_drive_speed;
   logic [DIST_W-1:0]          req_obstacle_distance;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_left_reverse;
   logic [DUTY_W-1:0]          rsp_left_duty;
   logic                       rsp_right_reverse;
   logic [DUTY_W-1:0]          rsp_right_duty;
   logic signed [ERR_W-1:0]    rsp_line_error;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   drive_scoreboard drive_board;
   bit              idle_on = 1;
   int              cycle_count = 0;

   line_follower_pd_drive uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_line_bits         (req_line_bits),
      .req_drive_speed       (req_drive_speed),
      .req_obstacle_distance (req_obstacle_distance),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_left_reverse      (rsp_left_reverse),
      .rsp_left_duty         (rsp_left_duty),
      .rsp_right_reverse     (rsp_right_reverse),
      .rsp_right_duty        (rsp_right_duty),
      .rsp_line_error        (rsp_line_error),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // stall the result side in short bursts
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && !reset && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         drive_board.check_response(drive_word_type'{left_reverse: rsp_left_reverse,
                                                     left_duty: rsp_left_duty,
                                                     right_reverse: rsp_right_reverse,
                                                     right_duty: rsp_right_duty,
                                                     line_error: rsp_line_error});
   end

   task automatic send_request(logic [LINE_BITS_W-1:0] bits, logic [SPEED_W-1:0] speed,
                               logic [DIST_W-1:0] distance);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_line_bits <= bits;
      req_drive_speed <= speed;
      req_obstacle_distance <= distance;
      do @(posedge clock); while (!req_ready);
      drive_board.note_request(bits, speed, distance);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      drive_board.write_register(index, data);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] prop, logic [CSR_DATA_W-1:0] deriv,
                            logic [CSR_DATA_W-1:0] limit);
      write_register(CSR_PROP_GAIN, prop);
      write_register(CSR_DERIV_GAIN, deriv);
      write_register(CSR_OBSTACLE_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   // hold the sender until every word is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (drive_board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 10'd1;
         2: return 10'd255;
         3: return 10'($urandom_range(0, 1023));
         default: return 10'($urandom_range(0, 8));
      endcase
   endfunction

   initial begin
      logic [LINE_BITS_W-1:0] bits;
      logic [SPEED_W-1:0]     speed;
      logic [DIST_W-1:0]      distance;
      logic [DIST_W-1:0]      limit;
      drive_board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_line_bits <= '0;
      req_drive_speed <= '0;
      req_obstacle_distance <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_PROP_GAIN;
      csr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(8'h00, 8'd100, 10'd1023);
      send_request(8'h18, 8'd0, 10'd1023);
      send_request(8'h08, 8'd255, 10'd500);
      send_request(8'h10, 8'd255, 10'd30);
      send_request(8'h01, 8'd50, 10'd29);
      send_request(8'h80, 8'd50, 10'd0);
      send_request(8'h00, 8'd50, 10'd200);
      send_request(8'h01, 8'd50, 10'd200);
      send_request(8'h00, 8'd50, 10'd200);
      send_request(8'h80, 8'd50, 10'd200);
      send_request(8'h81, 8'd120, 10'd200);
      send_request(8'h02, 8'd120, 10'd200);
      send_request(8'h40, 8'd120, 10'd200);
      send_request(8'h04, 8'd120, 10'd200);
      send_request(8'h20, 8'd120, 10'd200);
      send_request(8'hFF, 8'd255, 10'd1023);
      send_request(8'h42, 8'd7, 10'd1023);
      drain();
      write_register(CSR_UNUSED, 10'h3FF);
      configure(10'h3FF, 10'h2FF, 10'd0);
      send_request(8'h01, 8'd255, 10'd0);
      send_request(8'h80, 8'd0, 10'd0);
      send_request(8'h00, 8'd255, 10'd0);
      send_request(8'h18, 8'd128, 10'd1023);
      send_request(8'h04, 8'd0, 10'd5);
      drain();
      configure(10'd0, 10'd0, 10'd1023);
      send_request(8'h10, 8'd255, 10'd1023);
      send_request(8'h10, 8'd0, 10'd1022);

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on = (ph < PHASES - 2) && (ph % 3 != 2);
         drain();
         case ($urandom_range(0, 5))
            0: limit = '0;
            1: limit = 10'd1023;
            2: limit = OBSTACLE_LIMIT_RST;
            default: limit = 10'($urandom_range(0, 300));
         endcase
         configure(pick_gain(), pick_gain(), limit);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            case ($urandom_range(0, 9))
               0: bits = '0;
               1, 2: bits = 8'($urandom_range(0, 255));
               3, 4, 5, 6: bits = 8'd1 << $urandom_range(0, 7);
               default: bits = 8'd3 << $urandom_range(0, 6);
            endcase
            if ($urandom_range(0, 9) == 0) speed = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else speed = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
               0: distance = 10'($urandom_range(0, 1023));
               1: distance = (limit == 0) ? '0 : limit - 1'b1;
               default: distance = 10'($urandom_range(1023, limit));
            endcase
            send_request(bits, speed, distance);
         end
      end
      drain();

      if (drive_board.mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
sv/lfpd_pkg.sv
sv/line_follower_pd_drive.sv
sv/lfpd_checker.sv
tb/line_follower_pd_drive_test.sv
